/* sv/sit_pkg.sv */
// Shared types and constants for the sorted insert table.
// Used by the channel interfaces, the controller, the datapath and the top level.
package sit_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned WIDTH = 32;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OP_W  = 2;
  localparam int unsigned ST_W  = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the request fields
    logic exec;   // update the table and load the result register
  } ctrl_cmd_t;

endpackage

/* sv/sit_if.sv */
// Request and result channel interfaces for the sorted insert table.
// Depends on sit_pkg for field widths.
interface sit_req_if;
  logic                             valid;
  logic                             ready;
  logic [sit_pkg::OP_W-1:0]         opcode;
  logic [sit_pkg::WIDTH-1:0]        value;
  logic [sit_pkg::IDX_W-1:0]        index;

  modport source (output valid, output opcode, output value, output index, input ready);
  modport sink   (input valid, input opcode, input value, input index, output ready);
endinterface

interface sit_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [sit_pkg::WIDTH-1:0]        read_value;
  logic [sit_pkg::CNT_W-1:0]        entry_count;
  logic [sit_pkg::ST_W-1:0]         status;

  modport source (output valid, output read_value, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input read_value, input entry_count, input status,
                  output ready);
endinterface

/* sv/sit_ctrl.sv */
// Controller state machine for the sorted insert table.
// Depends on sit_pkg; drives the datapath through sit_pkg::ctrl_cmd_t.
module sit_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output sit_pkg::ctrl_cmd_t cmd_o
);

  sit_pkg::state_e state_q, state_d;
  logic            rsp_valid_q, rsp_valid_d;
  logic            rsp_free;

  assign rsp_free = !rsp_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sit_pkg::S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      sit_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sit_pkg::S_EXEC;
        end
      end
      sit_pkg::S_EXEC: begin
        // hold until the result register can take the new result
        if (rsp_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sit_pkg::S_IDLE;
        end
      end
      default: state_d = sit_pkg::S_IDLE;
    endcase

    if (cmd_o.exec) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q == sit_pkg::S_EXEC)
    else $error("accepted request did not move to execute");

  a_exec_loads_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> rsp_valid_q)
    else $error("executed item left no result");

  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == sit_pkg::S_EXEC)
    else $error("result appeared outside execute");

endmodule

/* sv/sit_dpath.sv */
// Datapath of the sorted insert table: entry cells, count, capacity and result registers.
// Depends on sit_pkg; controlled by sit_ctrl through sit_pkg::ctrl_cmd_t.
module sit_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sit_pkg::ctrl_cmd_t          cmd_i,
  input  logic                        cfg_we_i,
  input  logic [sit_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic [sit_pkg::OP_W-1:0]    opcode_i,
  input  logic [sit_pkg::WIDTH-1:0]   value_i,
  input  logic [sit_pkg::IDX_W-1:0]   index_i,
  output logic [sit_pkg::WIDTH-1:0]   read_value_o,
  output logic [sit_pkg::CNT_W-1:0]   entry_count_o,
  output logic [sit_pkg::ST_W-1:0]    status_o
);

  localparam int unsigned N = sit_pkg::DEPTH;

  logic [sit_pkg::WIDTH-1:0] entries_q [N];
  logic [sit_pkg::WIDTH-1:0] ins_row   [N];
  logic [sit_pkg::WIDTH-1:0] rem_row   [N];
  logic [N-1:0]              lt;

  sit_pkg::opcode_e          op_q;
  logic [sit_pkg::WIDTH-1:0] key_q;
  logic [sit_pkg::IDX_W-1:0] at_q;

  logic [sit_pkg::CNT_W-1:0] count_q, count_d;
  logic [sit_pkg::CNT_W-1:0] cap_q;
  logic [sit_pkg::CNT_W-1:0] limit;
  logic                      full;
  logic                      in_range;
  logic                      do_ins, do_rem;

  logic [sit_pkg::WIDTH-1:0] rd_d, rd_q;
  sit_pkg::status_e          st_d, st_q;
  logic [sit_pkg::CNT_W-1:0] cnt_q;

  // Each cell compares its entry with the key; the flags form a prefix in sorted order
  for (genvar g = 0; g < N; g++) begin : g_cell
    assign lt[g] = (sit_pkg::CNT_W'(g) < count_q) && (entries_q[g] < key_q);
    if (g == 0) begin : g_first
      assign ins_row[g] = lt[g] ? entries_q[g] : key_q;
    end else begin : g_rest
      assign ins_row[g] = lt[g]     ? entries_q[g] :
                          lt[g - 1] ? key_q        : entries_q[g - 1];
    end
    if (g == N - 1) begin : g_top
      assign rem_row[g] = (sit_pkg::IDX_W'(g) < at_q) ? entries_q[g] : '0;
    end else begin : g_low
      assign rem_row[g] = (sit_pkg::IDX_W'(g) < at_q) ? entries_q[g] : entries_q[g + 1];
    end
  end

  assign limit    = (cap_q < sit_pkg::CNT_W'(N)) ? cap_q : sit_pkg::CNT_W'(N);
  assign full     = (count_q >= limit) || (count_q >= sit_pkg::CNT_W'(N));
  assign in_range = {1'b0, at_q} < count_q;

  always_comb begin
    rd_d    = '0;
    st_d    = sit_pkg::ST_OK;
    count_d = count_q;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    case (op_q)
      sit_pkg::OP_INSERT: begin
        if (full) begin
          st_d = sit_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + sit_pkg::CNT_W'(1);
        end
      end
      sit_pkg::OP_LOOKUP: begin
        if (in_range) begin
          rd_d = entries_q[at_q];
        end else begin
          st_d = sit_pkg::ST_RANGE;
        end
      end
      sit_pkg::OP_REMOVE: begin
        if (in_range) begin
          do_rem  = 1'b1;
          count_d = count_q - sit_pkg::CNT_W'(1);
        end else begin
          st_d = sit_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= sit_pkg::CAP_RESET;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        count_q <= count_d;
      end
    end
  end

  // Entries above the count are never read, so the cells need no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= sit_pkg::opcode_e'(opcode_i);
      key_q <= value_i;
      at_q  <= index_i;
    end
    if (cmd_i.exec) begin
      rd_q  <= rd_d;
      st_q  <= st_d;
      cnt_q <= count_d;
      if (do_ins) begin
        entries_q <= ins_row;
      end else if (do_rem) begin
        entries_q <= rem_row;
      end
    end
  end

  assign read_value_o  = rd_q;
  assign entry_count_o = cnt_q;
  assign status_o      = st_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sit_pkg::CNT_W'(N))
    else $error("entry count above table depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && do_ins |=> count_q == $past(count_q) + sit_pkg::CNT_W'(1))
    else $error("insert did not advance the count");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && do_rem |=> count_q == $past(count_q) - sit_pkg::CNT_W'(1))
    else $error("remove did not drop the count");

endmodule

/* sv/sorted_insert_table.sv */
// Top level of the sorted insert table: ascending table of unsigned words.
// Depends on sit_pkg, sit_req_if/sit_rsp_if, sit_ctrl and sit_dpath.
//
//   channel  direction  handshake     payload
//   req_i    in         valid/ready   opcode, value, index
//   rsp_o    out        valid/ready   read_value, entry_count, status
//   cfg      in         cfg_we_i      cfg_wdata_i = capacity
//
// An item first has its request captured in S_IDLE; then, in S_EXEC, all entry
// cells compare against the key in parallel and shift in place.
// A finished result waits in the output register while the next request is taken;
// execution holds only when that register is still occupied.
// Reset clears the entry count and sets capacity to the full depth.
module sorted_insert_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sit_pkg::CNT_W-1:0] cfg_wdata_i,
  sit_req_if.sink                   req_i,
  sit_rsp_if.source                 rsp_o
);

  sit_pkg::ctrl_cmd_t cmd;

  sit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  sit_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (req_i.opcode),
    .value_i       (req_i.value),
    .index_i       (req_i.index),
    .read_value_o  (rsp_o.read_value),
    .entry_count_o (rsp_o.entry_count),
    .status_o      (rsp_o.status)
  );

endmodule
